// ----- design/bsim_pkg.sv -----
// Shared types and constants for the bank switch scanline IRQ mapper.
package bsim_pkg;

  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindTick  = 2'd1,
    KindProg  = 2'd2,
    KindPat   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CfgProgBanks  = 2'd0,
    CfgPatIsRam   = 2'd1,
    CfgFourScreen = 2'd2,
    CfgIrqVariant = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    IrqStandard   = 3'd0,
    IrqReloadZero = 3'd1,
    IrqPreset     = 3'd2,
    IrqLine0Adj   = 3'd3,
    IrqLatch7     = 3'd4,
    IrqPredec     = 3'd5
  } irq_variant_e;

  // Bank register picked by the low three bits of bank select.
  typedef enum logic [2:0] {
    SelPat0 = 3'd0,
    SelPat1 = 3'd1,
    SelPat2 = 3'd2,
    SelPat3 = 3'd3,
    SelPat4 = 3'd4,
    SelPat5 = 3'd5,
    SelPrgA = 3'd6,
    SelPrgB = 3'd7
  } bank_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // Register decode under the address mask.
  localparam logic [15:0] RegDecodeMask = 16'hE001;
  localparam logic [15:0] RegBankSel    = 16'h8000;
  localparam logic [15:0] RegBankData   = 16'h8001;
  localparam logic [15:0] RegMirror     = 16'hA000;
  localparam logic [15:0] RegIrqLatch   = 16'hC000;
  localparam logic [15:0] RegIrqReload  = 16'hC001;
  localparam logic [15:0] RegIrqDisable = 16'hE000;
  localparam logic [15:0] RegIrqEnable  = 16'hE001;

  localparam logic [7:0] PatEvenMask  = 8'hFE;
  localparam logic [7:0] PatRamMask   = 8'h07;
  localparam logic [7:0] Latch7Value  = 8'h07;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        display_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bank;
    logic       mirror_horizontal;
    logic       irq_line;
    logic [7:0] irq_count;
  } out_item_t;

endpackage

// ----- design/bsim_if.sv -----
// Valid/ready channel interfaces for mapper items and results.
interface bsim_in_if import bsim_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bsim_out_if import bsim_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- design/bank_switch_scanline_irq_mapper.sv -----
// Cartridge mapper: register decode, bank lookup and scanline IRQ counter.
// Output: a result is registered and valid in the cycle after its item transfers.
// Throughput: one item per cycle unless out_o stalls; the whole mapper
// state and result update is one combinational pass from input to registers.
// Reset: asynchronous active low; state and configuration return to power-up
// values and no result is pending.
module bank_switch_scanline_irq_mapper import bsim_pkg::*; #(
  parameter int unsigned VISIBLE_LINES = 240
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bsim_in_if.sink             in_i,
  bsim_out_if.source          out_o
);

  localparam logic [8:0] VisLines = 9'(VISIBLE_LINES);

  // Configuration
  logic [8:0] prog_banks_q;
  logic       pat_is_ram_q;
  logic       four_screen_q;
  logic [2:0] variant_q;

  // Mapper state
  logic [7:0] bank_sel_q, bank_sel_d;
  logic [7:0] prog_a_q, prog_a_d;
  logic [7:0] prog_b_q, prog_b_d;
  logic [7:0] pat_q [6];
  logic [7:0] pat_d [6];
  logic       mirror_q, mirror_d;
  logic [7:0] counter_q, counter_d;
  logic [7:0] reload_q, reload_d;
  logic       irq_en_q, irq_en_d;
  logic       irq_req_q, irq_req_d;
  logic       rel_pend_q, rel_pend_d;
  logic       rel_blank_q, rel_blank_d;
  logic       irq_out_q, irq_out_d;

  logic       out_valid_q;
  out_item_t  out_q;
  logic [7:0] bank_d;
  logic       accept;

  in_item_t   it;
  logic       high_addr;
  logic       latch_direct;
  logic       active;
  logic [7:0] fixed_lo, fixed_hi;
  logic [2:0] slot;
  logic [2:0] pat_idx;
  logic [7:0] pat_bank;
  logic [7:0] cnt;

  assign it       = in_i.item;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  assign high_addr    = it.address[15];
  assign latch_direct = (variant_q == IrqReloadZero) || (variant_q == IrqPredec);
  assign active       = (it.scanline < VisLines) && it.display_on;
  assign fixed_lo     = 8'(prog_banks_q - 9'd2);
  assign fixed_hi     = 8'(prog_banks_q - 9'd1);

  // Upper half of the pattern space swaps with the lower when bit 7 is set.
  assign slot     = it.address[12:10] ^ {bank_sel_q[7], 2'b00};
  assign pat_idx  = slot[2] ? ({1'b0, slot[1:0]} + 3'd2) : {2'b00, slot[1]};
  assign pat_bank = pat_q[pat_idx] + {7'd0, (~slot[2] & slot[0])};

  always_comb begin
    bank_sel_d  = bank_sel_q;
    prog_a_d    = prog_a_q;
    prog_b_d    = prog_b_q;
    pat_d       = pat_q;
    mirror_d    = mirror_q;
    counter_d   = counter_q;
    reload_d    = reload_q;
    irq_en_d    = irq_en_q;
    irq_req_d   = irq_req_q;
    rel_pend_d  = rel_pend_q;
    rel_blank_d = rel_blank_q;
    irq_out_d   = irq_out_q;
    bank_d      = 8'd0;
    cnt         = counter_q;

    case (it.kind)
      KindWrite: begin
        if (high_addr) begin
          case (it.address & RegDecodeMask)
            RegBankSel: bank_sel_d = it.data;
            RegBankData: begin
              case (bank_reg_e'(bank_sel_q[2:0]))
                SelPat0: pat_d[0] = it.data & PatEvenMask;
                SelPat1: pat_d[1] = it.data & PatEvenMask;
                SelPat2: pat_d[2] = it.data;
                SelPat3: pat_d[3] = it.data;
                SelPat4: pat_d[4] = it.data;
                SelPat5: pat_d[5] = it.data;
                SelPrgA: prog_a_d = it.data;
                default: prog_b_d = it.data;
              endcase
            end
            RegMirror: begin
              if (!four_screen_q) mirror_d = it.data[0];
            end
            RegIrqLatch: begin
              if (latch_direct) counter_d = it.data;
              else reload_d = it.data;
              if (variant_q == IrqLatch7) reload_d = Latch7Value;
            end
            RegIrqReload: begin
              if (latch_direct) begin
                reload_d = it.data;
              end else begin
                counter_d = counter_q | 8'h80;
                if ((it.scanline < VisLines) || (variant_q == IrqPreset)) begin
                  rel_pend_d = 1'b1;
                end else begin
                  rel_blank_d = 1'b1;
                  rel_pend_d  = 1'b0;
                end
              end
            end
            RegIrqDisable: begin
              irq_en_d  = 1'b0;
              irq_req_d = 1'b0;
              irq_out_d = 1'b0;
            end
            RegIrqEnable: begin
              irq_en_d  = 1'b1;
              irq_req_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      KindTick: begin
        if (variant_q == IrqReloadZero) begin
          if (active && irq_en_q) begin
            if (cnt == 8'd0) begin
              cnt       = reload_q;
              irq_req_d = 1'b1;
            end
            if (cnt != 8'd0) cnt = cnt - 8'd1;
            counter_d = cnt;
          end
          if (irq_req_d) irq_out_d = 1'b1;
        end else if (variant_q == IrqPredec) begin
          if (active && irq_en_q) begin
            cnt = cnt - 8'd1;
            if (cnt == 8'd0) begin
              irq_req_d = 1'b1;
              cnt       = reload_q;
            end
            counter_d = cnt;
          end
          if (irq_req_d) irq_out_d = 1'b1;
        end else if (active) begin
          if (rel_blank_q) begin
            cnt         = reload_q;
            rel_blank_d = 1'b0;
          end
          if (rel_pend_q) begin
            cnt        = reload_q;
            rel_pend_d = 1'b0;
            if ((variant_q == IrqLine0Adj) && (it.scanline == 9'd0)) cnt = cnt - 8'd1;
          end else if (cnt != 8'd0) begin
            cnt = cnt - 8'd1;
          end
          if (cnt == 8'd0) begin
            if (irq_en_q) begin
              irq_req_d = 1'b1;
              irq_out_d = 1'b1;
            end
            rel_pend_d = 1'b1;
          end
          counter_d = cnt;
        end
      end
      KindProg: begin
        if (high_addr) begin
          case (it.address[14:13])
            2'd0: bank_d = bank_sel_q[6] ? fixed_lo : prog_a_q;
            2'd1: bank_d = prog_b_q;
            2'd2: bank_d = bank_sel_q[6] ? prog_a_q : fixed_lo;
            default: bank_d = fixed_hi;
          endcase
        end
      end
      default: begin
        if (it.address[15:13] == 3'd0) begin
          bank_d = pat_is_ram_q ? (pat_bank & PatRamMask) : pat_bank;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_banks_q  <= 9'd32;
      pat_is_ram_q  <= 1'b0;
      four_screen_q <= 1'b0;
      variant_q     <= IrqStandard;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgProgBanks:  prog_banks_q  <= cfg_data_i;
        CfgPatIsRam:   pat_is_ram_q  <= cfg_data_i[0];
        CfgFourScreen: four_screen_q <= cfg_data_i[0];
        CfgIrqVariant: variant_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q  <= 8'd0;
      prog_a_q    <= 8'd0;
      prog_b_q    <= 8'd1;
      pat_q[0]    <= 8'd0;
      pat_q[1]    <= 8'd2;
      pat_q[2]    <= 8'd4;
      pat_q[3]    <= 8'd5;
      pat_q[4]    <= 8'd6;
      pat_q[5]    <= 8'd7;
      mirror_q    <= 1'b0;
      counter_q   <= 8'd0;
      reload_q    <= 8'hFF;
      irq_en_q    <= 1'b0;
      irq_req_q   <= 1'b0;
      rel_pend_q  <= 1'b0;
      rel_blank_q <= 1'b0;
      irq_out_q   <= 1'b0;
    end else if (accept) begin
      bank_sel_q  <= bank_sel_d;
      prog_a_q    <= prog_a_d;
      prog_b_q    <= prog_b_d;
      pat_q       <= pat_d;
      mirror_q    <= mirror_d;
      counter_q   <= counter_d;
      reload_q    <= reload_d;
      irq_en_q    <= irq_en_d;
      irq_req_q   <= irq_req_d;
      rel_pend_q  <= rel_pend_d;
      rel_blank_q <= rel_blank_d;
      irq_out_q   <= irq_out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload register: load on every input transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.bank              <= bank_d;
      out_q.mirror_horizontal <= mirror_d;
      out_q.irq_line          <= irq_out_d;
      out_q.irq_count         <= counter_d;
    end
  end

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while result stalled");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("transfer without result");

  a_disable_clears_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (it.kind == KindWrite) && high_addr &&
    ((it.address & RegDecodeMask) == RegIrqDisable) |=> !out_q.irq_line && !irq_out_q)
    else $error("irq disable write left irq asserted");

  a_ram_bank_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (it.kind == KindPat) && pat_is_ram_q |=> out_q.bank[7:3] == 5'd0)
    else $error("pattern RAM bank wider than 3 bits");
`endif

endmodule
